// ===== hdl/pbsa_pkg.sv =====
package pbsa_pkg;

	localparam int NumPages      = 64;
	localparam int NumTypes      = 16;
	localparam int SlotsPerPage  = 256;
	localparam int WordsPerPage  = SlotsPerPage / 64;
	localparam int PageW         = $clog2(NumPages);
	localparam int WordSelW      = $clog2(WordsPerPage);
	localparam int BitsAddrW     = PageW + WordSelW;
	localparam int BitsDepth     = NumPages * WordsPerPage;
	localparam int LiveW         = 9;
	localparam int DescW         = 14;
	localparam int TypeW         = 4;
	localparam int ClaimW        = PageW + 1;

	typedef enum logic [1:0] {
		FUNC_RESERVE = 2'd0,
		FUNC_RELEASE = 2'd1,
		FUNC_QUERY   = 2'd2,
		FUNC_QUERY_X = 2'd3
	} func_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_NO_PAGE   = 2'd1,
		ST_NOT_OCC   = 2'd2,
		ST_UNCLAIMED = 2'd3
	} status_t;

	typedef struct packed {
		logic [1:0]       func;
		logic [TypeW-1:0] entity_type;
		logic [DescW-1:0] descriptor;
	} req_t;

	typedef struct packed {
		logic [1:0]       status;
		logic [DescW-1:0] slot_descriptor;
		logic [LiveW-1:0] page_live_count;
	} rsp_t;

	// index of lowest clear bit of a 64-bit word
	function automatic logic [5:0] first_zero(input logic [63:0] w);
		logic [5:0] r;
		r = '0;
		for (int i = 63; i >= 0; i--) begin
			if (!w[i]) r = 6'(i);
		end
		return r;
	endfunction

endpackage

// ===== hdl/pbsa_chan_if.sv =====
interface pbsa_chan_if #(parameter type payload_t = logic);
	logic     valid;
	logic     ready;
	payload_t data;
	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

// ===== hdl/pbsa_ram.sv =====
module pbsa_ram #(
	parameter int Width = 64,
	parameter int Depth = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(Depth)-1:0] waddr,
	input  logic [Width-1:0]         wdata,
	input  logic [$clog2(Depth)-1:0] raddr,
	output logic [Width-1:0]         rdata
);
	logic [Width-1:0] mem [Depth];

	// write port and registered read
	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end
endmodule

// ===== hdl/pbsa_engine.sv =====
module pbsa_engine (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	input  pbsa_pkg::req_t  req,
	output logic            done,
	output pbsa_pkg::rsp_t  rsp,
	output logic            busy
);
	import pbsa_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE, S_CLEAR, S_SCAN, S_SCAN_RD, S_WORD_RD, S_WORD_CHK, S_PAGE_RD, S_PAGE_CHK,
		S_DONE
	} state_t;

	state_t               state_q;
	req_t                 req_q;
	logic [BitsAddrW-1:0] clr_q;
	logic [PageW-1:0]     page_q;
	logic [WordSelW-1:0]  word_q;
	logic [ClaimW-1:0]    claimed_q;
	logic [NumPages-1:0]  nonfull_q;
	logic [NumPages-1:0]  live_valid_q;

	// memory ports
	logic                 bits_we, live_we, own_we;
	logic [BitsAddrW-1:0] bits_waddr, bits_raddr;
	logic [63:0]          bits_wdata, bits_rdata;
	logic [PageW-1:0]     live_waddr, live_raddr, own_waddr, own_raddr;
	logic [LiveW-1:0]     live_wdata, live_rdata, live_cur;
	logic [TypeW-1:0]     own_wdata, own_rdata;

	pbsa_ram #(.Width(64), .Depth(BitsDepth)) u_bits (
		.clk, .we(bits_we), .waddr(bits_waddr), .wdata(bits_wdata),
		.raddr(bits_raddr), .rdata(bits_rdata));
	pbsa_ram #(.Width(LiveW), .Depth(NumPages)) u_live (
		.clk, .we(live_we), .waddr(live_waddr), .wdata(live_wdata),
		.raddr(live_raddr), .rdata(live_rdata));
	pbsa_ram #(.Width(TypeW), .Depth(NumPages)) u_owner (
		.clk, .we(own_we), .waddr(own_waddr), .wdata(own_wdata),
		.raddr(own_raddr), .rdata(own_rdata));

	assign live_cur = live_valid_q[page_q] ? live_rdata : '0;

	logic [5:0]           req_bit;
	logic [5:0]           fz;
	logic                 occ;
	logic [LiveW-1:0]     live_inc, live_dec;
	logic                 own_we_claim;
	assign req_bit  = req_q.descriptor[5:0];
	assign fz       = first_zero(bits_rdata);
	assign occ      = bits_rdata[req_bit];
	assign live_inc = live_cur + LiveW'(1);
	assign live_dec = (live_cur != '0) ? live_cur - LiveW'(1) : live_cur;

	// page claim at the end of an unsuccessful scan
	assign own_we_claim = !(ClaimW'(page_q) < claimed_q && nonfull_q[page_q]
			&& own_rdata == req_q.entity_type)
		&& !(ClaimW'(page_q) + ClaimW'(1) < claimed_q)
		&& (claimed_q < ClaimW'(NumPages));

	// memory addressing
	always_comb begin
		bits_we    = 1'b0;
		bits_waddr = {page_q, word_q};
		bits_wdata = bits_rdata;
		bits_raddr = {page_q, word_q};
		live_we    = 1'b0;
		live_waddr = page_q;
		live_wdata = live_inc;
		live_raddr = page_q;
		own_we     = 1'b0;
		own_waddr  = claimed_q[PageW-1:0];
		own_wdata  = req_q.entity_type;
		own_raddr  = page_q;
		unique case (state_q)
			S_CLEAR: begin
				bits_we    = 1'b1;
				bits_waddr = clr_q;
				bits_wdata = '0;
			end
			S_SCAN: begin
				own_we = own_we_claim;
			end
			S_WORD_CHK: begin
				if (bits_rdata != '1) begin
					bits_we    = 1'b1;
					bits_wdata = bits_rdata | (64'd1 << fz);
					live_we    = 1'b1;
				end
			end
			S_PAGE_CHK: begin
				if (req_q.func == FUNC_RELEASE && occ) begin
					bits_we    = 1'b1;
					bits_wdata = bits_rdata & ~(64'd1 << req_bit);
					live_we    = 1'b1;
					live_wdata = live_dec;
				end
			end
			default: ;
		endcase
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_CLEAR;
			clr_q         <= '0;
			claimed_q     <= '0;
			nonfull_q     <= '0;
			live_valid_q  <= '0;
			page_q        <= '0;
			word_q        <= '0;
			done          <= 1'b0;
		end else begin
			done <= 1'b0;
			unique case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + BitsAddrW'(1);
					if (clr_q == BitsAddrW'(BitsDepth - 1)) state_q <= S_IDLE;
				end
				S_IDLE: if (start) begin
					req_q  <= req;
					page_q <= '0;
					word_q <= '0;
					if (req.func == FUNC_RESERVE) begin
						state_q <= S_SCAN_RD;
					end else if (ClaimW'(req.descriptor[DescW-1 -: PageW]) >= claimed_q) begin
						rsp     <= '{ST_UNCLAIMED, req.descriptor, '0};
						state_q <= S_DONE;
					end else begin
						page_q  <= req.descriptor[DescW-1 -: PageW];
						word_q  <= req.descriptor[6 +: WordSelW];
						state_q <= S_PAGE_RD;
					end
				end
				S_SCAN_RD: state_q <= S_SCAN;
				// page owners scanned in turn, lowest first
				S_SCAN: begin
					if (ClaimW'(page_q) < claimed_q && nonfull_q[page_q]
							&& own_rdata == req_q.entity_type) begin
						word_q  <= '0;
						state_q <= S_WORD_RD;
					end else if (ClaimW'(page_q) + ClaimW'(1) < claimed_q) begin
						page_q  <= page_q + PageW'(1);
						state_q <= S_SCAN_RD;
					end else if (claimed_q >= ClaimW'(NumPages)) begin
						rsp     <= '{ST_NO_PAGE, '0, '0};
						state_q <= S_DONE;
					end else begin
						page_q    <= claimed_q[PageW-1:0];
						claimed_q <= claimed_q + ClaimW'(1);
						nonfull_q[claimed_q[PageW-1:0]]    <= 1'b1;
						live_valid_q[claimed_q[PageW-1:0]] <= 1'b0;
						word_q    <= '0;
						state_q   <= S_WORD_RD;
					end
				end
				S_WORD_RD: state_q <= S_WORD_CHK;
				S_WORD_CHK: begin
					if (bits_rdata != '1) begin
						live_valid_q[page_q] <= 1'b1;
						if (live_inc >= LiveW'(SlotsPerPage)) nonfull_q[page_q] <= 1'b0;
						rsp <= '{ST_OK, DescW'({page_q, word_q, fz}), live_inc};
						state_q <= S_DONE;
					end else if (word_q == WordSelW'(WordsPerPage - 1)) begin
						rsp     <= '{ST_NO_PAGE, '0, '0};
						state_q <= S_DONE;
					end else begin
						word_q  <= word_q + WordSelW'(1);
						state_q <= S_WORD_RD;
					end
				end
				S_PAGE_RD: state_q <= S_PAGE_CHK;
				S_PAGE_CHK: begin
					if (req_q.func == FUNC_RELEASE && occ) begin
						live_valid_q[page_q] <= 1'b1;
						nonfull_q[page_q]    <= 1'b1;
						rsp <= '{ST_OK, req_q.descriptor, live_dec};
					end else begin
						rsp <= '{occ ? ST_OK : ST_NOT_OCC, req_q.descriptor, live_cur};
					end
					state_q <= S_DONE;
				end
				S_DONE: begin
					done    <= 1'b1;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign busy = (state_q != S_IDLE);
endmodule

// ===== hdl/paged_bitmap_slot_allocator_core.sv =====
// channel  dir  handshake     payload
// req      in   valid/ready   func, entity_type, descriptor
// rsp      out  valid/ready   status, slot_descriptor, page_live_count
//
// release and query read and check the page, or answer at once when the page is
// unclaimed; reserve reads and checks each page owner scanned, then each occupancy
// word read; after reset a clearing pass over the 256 occupancy words holds
// req.ready low; one item is worked at a time
// the next item is taken once the output register is empty or being emptied
module paged_bitmap_slot_allocator_core (
	input  logic clk,
	input  logic arst_n,
	pbsa_chan_if.sink   req,
	pbsa_chan_if.source rsp
);
	import pbsa_pkg::*;

	logic start, done, busy, pend_q;
	rsp_t eng_rsp;

	// one item in flight; accept when engine idle, no result pending, output free
	assign req.ready = !busy && !pend_q && (!rsp.valid || rsp.ready);
	assign start     = req.valid && req.ready;

	pbsa_engine u_engine (
		.clk, .arst_n, .start, .req(req.data), .done, .rsp(eng_rsp), .busy);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q    <= 1'b0;
			rsp.valid <= 1'b0;
		end else begin
			if (rsp.valid && rsp.ready) rsp.valid <= 1'b0;
			if (done) begin
				rsp.valid <= 1'b1;
				rsp.data  <= eng_rsp;
			end
			pend_q <= (pend_q || start) && !done;
		end
	end

	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		busy |-> !req.ready) else $error("accepted while busy");
	a_done_pending: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(pend_q)) else $error("result without request");
	a_one_flight: assert property (@(posedge clk) disable iff (!arst_n)
		start |=> pend_q) else $error("item lost");
endmodule

// ===== dv/tb_top.sv =====
module tb_top;
	import pbsa_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	// allocator shadow: occupancy, owners, live counts, claimed pages
	class slot_scoreboard;
		bit [255:0] occ[NumPages];
		bit [3:0]   owner[NumPages];
		int         live[NumPages];
		bit [63:0]  nonfull;
		int         claimed;
		rsp_t       pending[$];
		int         errors;

		function void clear_state();
			for (int p = 0; p < NumPages; p++) begin
				occ[p] = '0;
				owner[p] = '0;
				live[p] = 0;
			end
			nonfull = '0;
			claimed = 0;
			errors = 0;
		endfunction

		// predict the response of one accepted request beat
		function void note_request(req_t r);
			rsp_t e;
			int pg;
			int sl;
			int found;
			pg = int'(r.descriptor) / SlotsPerPage;
			sl = int'(r.descriptor) % SlotsPerPage;
			found = -1;
			e = '0;
			if (r.func == FUNC_RESERVE) begin
				for (int p = 0; p < claimed; p++) begin
					if (found < 0 && nonfull[p] && owner[p] == r.entity_type) found = p;
				end
				if (found < 0 && claimed < NumPages) begin
					found = claimed;
					owner[found] = r.entity_type;
					live[found] = 0;
					nonfull[found] = 1'b1;
					claimed++;
				end
				e.status = ST_NO_PAGE;
				if (found >= 0) begin
					sl = -1;
					for (int s = SlotsPerPage - 1; s >= 0; s--) begin
						if (!occ[found][s]) sl = s;
					end
					if (sl >= 0) begin
						occ[found][sl] = 1'b1;
						live[found]++;
						if (live[found] >= SlotsPerPage) nonfull[found] = 1'b0;
						e.status = ST_OK;
						e.slot_descriptor = DescW'(found * SlotsPerPage + sl);
						e.page_live_count = LiveW'(live[found]);
					end
				end
			end else if (pg >= claimed) begin
				e.status = ST_UNCLAIMED;
				e.slot_descriptor = r.descriptor;
			end else begin
				e.slot_descriptor = r.descriptor;
				if (!occ[pg][sl]) begin
					e.status = ST_NOT_OCC;
				end else if (r.func == FUNC_RELEASE) begin
					occ[pg][sl] = 1'b0;
					if (live[pg] > 0) live[pg]--;
					nonfull[pg] = 1'b1;
					e.status = ST_OK;
				end else begin
					e.status = ST_OK;
				end
				e.page_live_count = LiveW'(live[pg]);
			end
			pending = {pending, e};
		endfunction

		// compare one response beat with the oldest prediction
		function void check_response(rsp_t a);
			rsp_t e;
			if (pending.size() == 0) begin
				$display("%0t unexpected response %h", $realtime, a);
				errors++;
				return;
			end
			e = pending.pop_front();
			if (a.status !== e.status) begin
				$display("%0t status exp %0d act %0d", $realtime, e.status, a.status);
				errors++;
			end
			if (a.slot_descriptor !== e.slot_descriptor) begin
				$display("%0t descriptor exp %0d act %0d", $realtime,
					e.slot_descriptor, a.slot_descriptor);
				errors++;
			end
			if (a.page_live_count !== e.page_live_count) begin
				$display("%0t live count exp %0d act %0d", $realtime,
					e.page_live_count, a.page_live_count);
				errors++;
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	pbsa_chan_if #(.payload_t(req_t)) req_ch ();
	pbsa_chan_if #(.payload_t(rsp_t)) rsp_ch ();

	paged_bitmap_slot_allocator_core u_top (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (req_ch.sink),
		.rsp   (rsp_ch.source)
	);

	slot_scoreboard sb;
	longint cycle_count;
	int     hold_cycles;
	bit     stall_on;
	bit     done_sending;

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// cycle limit
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > 600000) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	// note request beats and check response beats
	always @(posedge clk) begin
		if (arst_n && req_ch.valid && req_ch.ready) sb.note_request(req_ch.data);
		if (arst_n && rsp_ch.valid && rsp_ch.ready) sb.check_response(rsp_ch.data);
	end

	// receiver stall pattern, with one long hold-off
	always @(posedge clk) begin
		if (hold_cycles > 0) begin
			hold_cycles <= hold_cycles - 1;
			rsp_ch.ready <= 1'b0;
		end else if (stall_on) begin
			rsp_ch.ready <= ($urandom_range(0, 3) != 0);
		end else begin
			rsp_ch.ready <= 1'b1;
		end
	end

	// drive one request beat, waiting for acceptance
	task automatic send_beat(input logic [1:0] f, input logic [3:0] t,
		input logic [DescW-1:0] d);
		req_t r;
		r.func = f;
		r.entity_type = t;
		r.descriptor = d;
		req_ch.valid <= 1'b1;
		req_ch.data <= r;
		@(posedge clk);
		while (!req_ch.ready) @(posedge clk);
	endtask

	task automatic idle_cycles(input int n);
		req_ch.valid <= 1'b0;
		repeat (n) @(posedge clk);
	endtask

	task automatic drain_responses();
		req_ch.valid <= 1'b0;
		while (sb.pending.size() != 0) @(posedge clk);
	endtask

	// random request weighted toward plausible descriptors
	task automatic send_random();
		int k;
		logic [DescW-1:0] d;
		k = $urandom_range(0, 9);
		d = DescW'($urandom);
		if (sb.claimed > 0 && k < 7)
			d = DescW'($urandom_range(0, sb.claimed - 1) * SlotsPerPage
				+ $urandom_range(0, 7) * (($urandom_range(0, 3) == 0) ? 32 : 1));
		if (k < 4) send_beat(FUNC_RESERVE, 4'($urandom_range(0, 3)), d);
		else if (k < 6) send_beat(FUNC_RELEASE, 4'($urandom), d);
		else if (k < 9) send_beat(FUNC_QUERY, 4'($urandom), d);
		else send_beat(2'($urandom), 4'($urandom), d);
	endtask

	initial begin
		int n;
		sb = new();
		sb.clear_state();
		cycle_count = 0;
		hold_cycles = 0;
		stall_on = 1'b0;
		done_sending = 1'b0;
		arst_n = 1'b0;
		req_ch.valid = 1'b0;
		req_ch.data = '0;
		rsp_ch.ready = 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// directed: unclaimed pages, first reserves, free slot, odd func
		send_beat(FUNC_QUERY, 4'd0, 14'd0);
		send_beat(FUNC_RELEASE, 4'hf, 14'h3fff);
		send_beat(FUNC_RESERVE, 4'd0, 14'h3fff);
		send_beat(FUNC_RESERVE, 4'd0, 14'd0);
		send_beat(FUNC_RESERVE, 4'hf, 14'd0);
		send_beat(FUNC_QUERY, 4'd0, 14'd1);
		send_beat(FUNC_QUERY_X, 4'd0, 14'd256);
		send_beat(FUNC_QUERY, 4'd0, 14'd5);
		send_beat(FUNC_RELEASE, 4'd0, 14'd0);
		send_beat(FUNC_RELEASE, 4'd0, 14'd0);
		send_beat(FUNC_RESERVE, 4'd0, 14'd0);
		send_beat(FUNC_QUERY, 4'd0, 14'd512);
		drain_responses();

		// fill page 0 past the word boundaries to the full state
		stall_on = 1'b1;
		for (int i = 0; i < 256; i++) send_beat(FUNC_RESERVE, 4'd0, 14'd0);
		send_beat(FUNC_RELEASE, 4'd0, 14'd100);
		send_beat(FUNC_RESERVE, 4'd0, 14'd0);
		send_beat(FUNC_QUERY, 4'd0, 14'd255);

		// long receiver hold-off while requests keep coming
		hold_cycles = 400;
		for (int i = 0; i < 10; i++) send_random();
		drain_responses();

		// random bursts with gaps
		n = 0;
		while (n < 150) begin
			for (int b = $urandom_range(1, 12); b > 0; b--) begin
				send_random();
				n++;
			end
			if ($urandom_range(0, 2) == 0) idle_cycles($urandom_range(1, 20));
			stall_on = ($urandom_range(0, 3) != 0);
		end

		// one reserve for every type, claiming fresh pages
		for (int t = 0; t < 16; t++) send_beat(FUNC_RESERVE, 4'(t), 14'd0);
		send_beat(FUNC_QUERY, 4'd0, 14'h3fff);
		for (int i = 0; i < 60; i++) send_random();
		drain_responses();
		done_sending = 1'b1;
		repeat (200) @(posedge clk);
		if (sb.errors == 0 && sb.pending.size() == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end
endmodule
